// ===== rtl/core/rpn_stack_calculator_assert.svh =====
// ----------------------------------------------------------------------------
// RPN stack calculator assertion macros
// Shared property templates, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_CALCULATOR_ASSERT_SVH
`define RPN_STACK_CALCULATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RPN_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RPN_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/rpn_pkg.sv =====
// ----------------------------------------------------------------------------
// RPN calculator package
// Sizes, command and status codes, and the controller-datapath interface.
// ----------------------------------------------------------------------------
package rpn_pkg;

   localparam int STACK_DEPTH = 10;
   localparam int DEPTH_W = ($clog2(STACK_DEPTH + 1) > 4) ? $clog2(STACK_DEPTH + 1) : 4;
   localparam int MEM_AW = $clog2(STACK_DEPTH);

   // Divider: 48-bit dividend magnitude, two quotient bits per cycle.
   localparam int DIV_W = 48;
   localparam int DIV_PER_CYC = 2;
   localparam int DIV_STEPS = DIV_W / DIV_PER_CYC;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   localparam logic [2:0] CMD_PUSH = 3'd0;
   localparam logic [2:0] CMD_ADD  = 3'd1;
   localparam logic [2:0] CMD_SUB  = 3'd2;
   localparam logic [2:0] CMD_MUL  = 3'd3;
   localparam logic [2:0] CMD_DIV  = 3'd4;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_FULL    = 3'd1;
   localparam logic [2:0] ST_FEW     = 3'd2;
   localparam logic [2:0] ST_DIVZERO = 3'd3;
   localparam logic [2:0] ST_HALTED  = 3'd4;

   localparam logic [1:0] WB_ADD = 2'd0;
   localparam logic [1:0] WB_SUB = 2'd1;
   localparam logic [1:0] WB_MUL = 2'd2;
   localparam logic [1:0] WB_DIV = 2'd3;

   typedef struct packed {
      logic       capture;
      logic       push;
      logic       rd_second;
      logic       mul_start;
      logic       div_start;
      logic       wb_en;
      logic [1:0] wb_sel;
      logic       rsp_load;
   } rpn_cmd_type;

   typedef struct packed {
      logic full;
      logic few;
      logic top_zero;
      logic div_done;
   } rpn_stat_type;

endpackage

// ===== rtl/core/rpn_div.sv =====
// ----------------------------------------------------------------------------
// RPN fixed-point divider
// Radix-4 restoring divider computing (a * 2^16) / b, truncated toward zero,
// saturated to 32 bits.
// ----------------------------------------------------------------------------
module rpn_div import rpn_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] dividend,
   input  logic signed [31:0] divisor,
   output logic               done,
   output logic signed [31:0] quotient
);

   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [31:0]          rem_ff, rem_in;
   logic [31:0]          den_ff;
   logic                 neg_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;

   logic [31:0]          mag_a, mag_b;
   logic [31:0]          r_v;
   logic [DIV_W-1:0]     q_v;
   logic [32:0]          t_v;

   assign mag_a = dividend[31] ? (~dividend + 32'd1) : dividend;
   assign mag_b = divisor[31] ? (~divisor + 32'd1) : divisor;

   // The remainder stays below the divisor, so 32 bits hold it between steps.
   always_comb begin
      r_v = rem_ff;
      q_v = quo_ff;
      t_v = '0;
      for (int i = 0; i < DIV_PER_CYC; i++) begin
         t_v = {r_v, q_v[DIV_W-1]};
         q_v = {q_v[DIV_W-2:0], 1'b0};
         if (t_v >= {1'b0, den_ff}) begin
            t_v = t_v - {1'b0, den_ff};
            q_v[0] = 1'b1;
         end
         r_v = t_v[31:0];
      end
      rem_in = r_v;
      quo_in = q_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == DIV_CNT_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(DIV_STEPS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= {mag_a, 16'd0};
         rem_ff <= '0;
         den_ff <= mag_b;
         neg_ff <= dividend[31] ^ divisor[31];
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   always_comb begin
      if (!neg_ff) begin
         quotient = (|quo_ff[DIV_W-1:31]) ? 32'sh7FFF_FFFF : $signed(quo_ff[31:0]);
      end else if (quo_ff > DIV_W'(33'h0_8000_0000)) begin
         quotient = 32'sh8000_0000;
      end else begin
         quotient = $signed(~quo_ff[31:0] + 32'd1);
      end
   end

   assign done = done_ff;

endmodule

// ===== rtl/core/rpn_datapath.sv =====
// ----------------------------------------------------------------------------
// RPN calculator datapath
// Top-of-stack register, stack memory for the entries below it, arithmetic
// units and the result register.
// ----------------------------------------------------------------------------
module rpn_datapath import rpn_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  rpn_cmd_type        cmd,
   input  logic signed [31:0] req_value,
   output rpn_stat_type       stat,
   output logic signed [31:0] rsp_top_value,
   output logic [3:0]         rsp_depth
);

   // The top entry lives in top_ff; the entries below it live in stack_mem, bottom entry in stack_mem[0].
   logic [31:0]          stack_mem [STACK_DEPTH];
   logic signed [31:0]   top_ff, top_in;
   logic signed [31:0]   sec_ff;
   logic signed [31:0]   value_ff;
   logic [DEPTH_W-1:0]   depth_ff, depth_in;
   logic signed [63:0]   prod_ff;
   logic signed [31:0]   rsp_top_ff;
   logic [3:0]           rsp_depth_ff;

   logic [DEPTH_W-1:0]   depth_m1, depth_m2;
   logic signed [32:0]   sum_v, diff_v;
   logic signed [63:0]   rnd_v;
   logic [47:0]          mq_v;
   logic signed [31:0]   add_res, sub_res, mul_res, div_res;
   logic                 div_done;

   function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
      if (v[32] != v[31]) begin
         sat33 = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         sat33 = v[31:0];
      end
   endfunction

   assign depth_m1 = depth_ff - DEPTH_W'(1);
   assign depth_m2 = depth_ff - DEPTH_W'(2);

   assign sum_v  = {sec_ff[31], sec_ff} + {top_ff[31], top_ff};
   assign diff_v = {sec_ff[31], sec_ff} - {top_ff[31], top_ff};
   assign add_res = sat33(sum_v);
   assign sub_res = sat33(diff_v);

   // Round to nearest with ties upward, then drop the 16 fraction bits.
   assign rnd_v = prod_ff + 64'sd32768;
   assign mq_v  = rnd_v[63:16];
   assign mul_res = ((&mq_v[47:31]) || !(|mq_v[47:31])) ? $signed(mq_v[31:0])
                    : (mq_v[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

   rpn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sec_ff),
      .divisor  (top_ff),
      .done     (div_done),
      .quotient (div_res)
   );

   always_comb begin
      top_in   = top_ff;
      depth_in = depth_ff;
      if (cmd.push) begin
         top_in   = value_ff;
         depth_in = depth_ff + DEPTH_W'(1);
      end else if (cmd.wb_en) begin
         depth_in = depth_m1;
         case (cmd.wb_sel)
            WB_ADD:  top_in = add_res;
            WB_SUB:  top_in = sub_res;
            WB_MUL:  top_in = mul_res;
            WB_DIV:  top_in = div_res;
            default: top_in = top_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (cmd.capture) begin
         value_ff <= req_value;
      end
      if (cmd.mul_start) begin
         prod_ff <= 64'(sec_ff) * 64'(top_ff);
      end
      if (cmd.rsp_load) begin
         rsp_top_ff   <= (depth_ff == '0) ? 32'sd0 : top_ff;
         rsp_depth_ff <= depth_ff[3:0];
      end
   end

   // Pushing spills the old top into the memory; an operation reads the
   // second entry back.
   always_ff @(posedge clock) begin
      if (cmd.push && (depth_ff != '0)) begin
         stack_mem[depth_m1[MEM_AW-1:0]] <= top_ff;
      end
      if (cmd.rd_second) begin
         sec_ff <= $signed(stack_mem[depth_m2[MEM_AW-1:0]]);
      end
   end

   assign stat.full     = (depth_ff == DEPTH_W'(STACK_DEPTH));
   assign stat.few      = (depth_ff < DEPTH_W'(2));
   assign stat.top_zero = (top_ff == 32'sd0);
   assign stat.div_done = div_done;

   assign rsp_top_value = rsp_top_ff;
   assign rsp_depth     = rsp_depth_ff;

endmodule

// ===== rtl/core/rpn_ctrl.sv =====
// ----------------------------------------------------------------------------
// RPN calculator controller
// Sequences one command at a time through the datapath, tracks the halted
// condition and owns the handshakes.
// ----------------------------------------------------------------------------
module rpn_ctrl import rpn_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [2:0]   req_cmd,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [2:0]   rsp_status,
   input  rpn_stat_type stat,
   output rpn_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DISP  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [2:0] cmd_ff;
   logic [2:0] status_ff, status_in;
   logic [2:0] rsp_status_ff;
   logic       halted_ff, halted_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      halted_in    = halted_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DISP;
            end
         end
         S_DISP: begin
            status_in = ST_OK;
            state_in  = S_RESP;
            if (halted_ff) begin
               status_in = ST_HALTED;
            end else begin
               case (cmd_ff)
                  CMD_PUSH: begin
                     if (stat.full) begin
                        status_in = ST_FULL;
                     end else begin
                        cmd.push = 1'b1;
                     end
                  end
                  CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                     if (stat.few) begin
                        status_in = ST_FEW;
                     end else begin
                        cmd.rd_second = 1'b1;
                        state_in      = S_READ;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_READ: begin
            state_in = S_RESP;
            case (cmd_ff)
               CMD_ADD: begin
                  cmd.wb_en  = 1'b1;
                  cmd.wb_sel = WB_ADD;
               end
               CMD_SUB: begin
                  cmd.wb_en  = 1'b1;
                  cmd.wb_sel = WB_SUB;
               end
               CMD_MUL: begin
                  cmd.mul_start = 1'b1;
                  state_in      = S_MUL;
               end
               CMD_DIV: begin
                  if (stat.top_zero) begin
                     status_in = ST_DIVZERO;
                  end else begin
                     cmd.div_start = 1'b1;
                     state_in      = S_DIV;
                  end
               end
               default: state_in = S_RESP;
            endcase
         end
         S_MUL: begin
            cmd.wb_en  = 1'b1;
            cmd.wb_sel = WB_MUL;
            state_in   = S_RESP;
         end
         S_DIV: begin
            if (stat.div_done) begin
               cmd.wb_en  = 1'b1;
               cmd.wb_sel = WB_DIV;
               state_in   = S_RESP;
            end
         end
         S_RESP: begin
            // Wait for the result register to free up, then hand the result over.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               halted_in    = halted_ff || (status_ff != ST_OK);
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= ST_OK;
      end else begin
         state_ff     <= state_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= req_cmd;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
      end
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

endmodule

// ===== rtl/core/rpn_stack_calculator.sv =====
// ----------------------------------------------------------------------------
// RPN stack calculator
// Usage: each request carries req_cmd (push, add, subtract, multiply, divide)
// and req_value, a signed Q16.16 operand used only by push. Every request
// produces exactly one response with rsp_status, rsp_top_value (zero when the
// stack is empty) and rsp_depth. Both channels use valid/ready.
// One command is processed at a time. After acceptance, push, halted, unknown
// and rejected commands go from dispatch to the response state; add and
// subtract first read the second entry back (as does a zero divisor),
// multiply also waits on one registered 32x32 product, and divide waits for
// the radix-4 divider, which retires two of 48 quotient bits per cycle. The
// next request can be accepted the cycle after the response register is
// loaded.
// The response register decouples the sides: a new transaction is taken
// while the previous result waits, and a stalled receiver only holds the
// controller once a second result is ready.
// After any error the block reports halted on every request until reset.
// Synchronous reset empties the stack and clears the halted condition.
// ----------------------------------------------------------------------------
module rpn_stack_calculator import rpn_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_cmd,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_top_value,
   output logic [3:0]         rsp_depth
);

   rpn_cmd_type  dp_cmd;
   rpn_stat_type dp_stat;

   rpn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_cmd    (req_cmd),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .stat       (dp_stat),
      .cmd        (dp_cmd)
   );

   rpn_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (dp_cmd),
      .req_value     (req_value),
      .stat          (dp_stat),
      .rsp_top_value (rsp_top_value),
      .rsp_depth     (rsp_depth)
   );

endmodule

// ===== rtl/core/rpn_checker.sv =====
// ----------------------------------------------------------------------------
// RPN calculator port checker
// Watches the top-level ports for handshake and halting behavior.
// ----------------------------------------------------------------------------
`include "rpn_stack_calculator_assert.svh"

module rpn_checker import rpn_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [2:0]         rsp_status,
   input logic signed [31:0] rsp_top_value,
   input logic [3:0]         rsp_depth
);

   logic        seen_err_ff;
   logic        req_fire;
   logic        rsp_stall;
   logic        rsp_empty;
   logic        rsp_after_err;
   logic [38:0] rsp_bits;

   assign req_fire      = req_valid && req_ready;
   assign rsp_stall     = rsp_valid && !rsp_ready;
   assign rsp_empty     = rsp_valid && (rsp_depth == 4'd0);
   assign rsp_after_err = rsp_valid && seen_err_ff;
   assign rsp_bits      = {rsp_status, rsp_top_value, rsp_depth};

   // Remembers that an error response has been delivered.
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_err_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && (rsp_status != ST_OK)) begin
         seen_err_ff <= 1'b1;
      end
   end

   `RPN_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_bits), "Stalled rsp changed.")
   `RPN_ASSERT_NEXT(a_one_at_a_time, req_fire, !req_ready, "Request accepted while busy.")
   `RPN_ASSERT_SAME(a_empty_zero, rsp_empty, rsp_top_value == 32'sd0, "Empty stack, nonzero top.")
   `RPN_ASSERT_SAME(a_halt_sticky, rsp_after_err, rsp_status == ST_HALTED, "Halt not sticky.")

endmodule

bind rpn_stack_calculator rpn_checker u_rpn_checker (.*);

// ===== bench/rpn_stack_calculator_check.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RPN stack calculator response checker
// Watches both channels, keeps its own copy of the operand stack and the
// halt flag, works out the response for each accepted request and compares
// every accepted response field by field with the oldest pending one.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_check import rpn_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [2:0]         req_cmd,
   input  logic signed [31:0] req_value,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [2:0]         rsp_status,
   input  logic signed [31:0] rsp_top_value,
   input  logic [3:0]         rsp_depth,
   output int                 mismatch_count,
   output int                 pending_count
);

   localparam logic signed [63:0] WIDE_MAX = 64'sd2147483647;
   localparam logic signed [63:0] WIDE_MIN = -64'sd2147483648;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] top_value;
      logic [3:0]         depth;
   } calc_result_type;

   logic signed [31:0] calc_stack [STACK_DEPTH];
   int unsigned        calc_depth = 0;
   bit                 calc_halted = 1'b0;
   calc_result_type    pending_results [$];
   int                 responses_seen = 0;

   initial begin
      mismatch_count = 0;
      pending_count = 0;
   end

   function automatic logic signed [31:0] saturate(input logic signed [63:0] wide);
      if (wide > WIDE_MAX) return WIDE_MAX[31:0];
      if (wide < WIDE_MIN) return WIDE_MIN[31:0];
      return wide[31:0];
   endfunction

   // Applies one command to the shadow stack and returns the response it gives.
   function automatic calc_result_type apply_command(input logic [2:0] cmd,
                                                     input logic signed [31:0] value);
      logic signed [63:0] wide_top;
      logic signed [63:0] wide_second;
      logic signed [31:0] outcome;
      logic [2:0]         status;
      calc_result_type    result;
      status = ST_OK;
      outcome = '0;
      if (calc_halted) begin
         status = ST_HALTED;
      end else if (cmd == CMD_PUSH) begin
         if (calc_depth >= STACK_DEPTH) begin
            status = ST_FULL;
         end else begin
            calc_stack[calc_depth] = value;
            calc_depth++;
         end
      end else if (cmd <= CMD_DIV) begin
         if (calc_depth < 2) begin
            status = ST_FEW;
         end else begin
            wide_top = calc_stack[calc_depth - 1];
            wide_second = calc_stack[calc_depth - 2];
            case (cmd)
               CMD_ADD: outcome = saturate(wide_second + wide_top);
               CMD_SUB: outcome = saturate(wide_second - wide_top);
               // Round to nearest with ties toward plus infinity.
               CMD_MUL: outcome = saturate((wide_second * wide_top + 64'sd32768) >>> 16);
               default: begin
                  if (wide_top == 0) status = ST_DIVZERO;
                  else outcome = saturate((wide_second <<< 16) / wide_top);
               end
            endcase
            if (status == ST_OK) begin
               calc_depth--;
               calc_stack[calc_depth - 1] = outcome;
            end
         end
      end
      if (status != ST_OK) calc_halted = 1'b1;
      result.status = status;
      result.top_value = (calc_depth != 0) ? calc_stack[calc_depth - 1] : '0;
      result.depth = 4'(calc_depth);
      return result;
   endfunction

   task automatic report_mismatch(input string field, input longint got, input longint want);
      mismatch_count++;
      $display("[%0t] response %0d: %s is %0d, expected %0d",
               $time, responses_seen, field, got, want);
   endtask

   always @(posedge clock) begin
      calc_result_type want;
      if (reset) begin
         calc_depth = 0;
         calc_halted = 1'b0;
         pending_results.delete();
         pending_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("transaction with nothing pending, status",
                               rsp_status, 0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_top_value !== want.top_value)
                  report_mismatch("top value", rsp_top_value, want.top_value);
               if (rsp_depth !== want.depth)
                  report_mismatch("depth", rsp_depth, want.depth);
            end
            responses_seen++;
         end
         if (req_valid && req_ready)
            pending_results.push_back(apply_command(req_cmd, req_value));
         pending_count = pending_results.size();
      end
   end

endmodule

// ===== bench/rpn_stack_calculator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RPN stack calculator testbench
// Drives push, arithmetic and spare command codes through the request channel with random
// gaps and response back-pressure: a directed run over saturation, rounding
// and truncation corners, random well-formed command streams that walk the
// stack between one entry and full, and a closing error that halts the block.
// Checking is done by the response checker instantiated beside the block.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_tb import rpn_pkg::*; ();

   localparam int CYCLE_LIMIT = 1000000;
   localparam int END_WAIT = 64;
   localparam int LONG_HOLD = 300;
   localparam int PHASE_COUNT = 7;
   localparam int PHASE_ITEMS = 250;
   localparam logic [2:0] CMD_SPARE_FIRST = CMD_DIV + 3'd1;
   localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VAL_ULP = 32'sh0000_0001;
   localparam logic signed [31:0] VAL_HALF = 32'sh0000_8000;
   localparam logic signed [31:0] VAL_TWO = 32'sh0002_0000;

   typedef enum {HALT_BY_FULL, HALT_BY_FEW, HALT_BY_ZERO_DIVISOR} halt_cause_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_cmd = CMD_PUSH;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_status;
   logic signed [31:0] rsp_top_value;
   logic [3:0]         rsp_depth;
   int                 mismatches;
   int                 pending;

   // Stimulus-side view of the stack, just enough to keep sequences legal.
   int  stack_fill = 0;
   bit  top_nonzero = 1'b0;
   bit  tx_idle_on = 1'b1;
   bit  rx_idle_on = 1'b1;
   int  rx_hold_cycles = 0;
   int  cycle_count = 0;

   rpn_stack_calculator dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_top_value(rsp_top_value),
      .rsp_depth(rsp_depth)
   );

   rpn_stack_calculator_check calc_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_top_value(rsp_top_value),
      .rsp_depth(rsp_depth),
      .mismatch_count(mismatches),
      .pending_count(pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d responses pending", cycle_count, pending);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Mostly back-to-back, sometimes a short gap, rarely a long pause.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return VAL_MAX;
         1: return VAL_MIN;
         2: begin
            case ($urandom_range(0, 2))
               0: return '0;
               1: return VAL_ULP;
               default: return -VAL_ULP;
            endcase
         end
         3, 4: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
         5, 6: return $urandom;
         default: return $signed({{12{$urandom_range(0, 1) == 1}}, 20'($urandom)});
      endcase
   endfunction

   function automatic logic signed [31:0] pick_nonzero();
      logic signed [31:0] value;
      value = pick_value();
      while (value == 0) value = pick_value();
      return value;
   endfunction

   function automatic logic [2:0] pick_operation();
      case ($urandom_range(0, 3))
         0: return CMD_ADD;
         1: return CMD_SUB;
         2: return CMD_MUL;
         default: return CMD_DIV;
      endcase
   endfunction

   initial begin
      int stall_left;
      stall_left = 0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (rx_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            rx_hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            stall_left = pick_gap();
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offers one transaction and returns at the edge where it is accepted.
   task automatic send_item(input logic [2:0] cmd, input logic signed [31:0] value);
      int gap;
      gap = tx_idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      if (cmd == CMD_PUSH) begin
         if (stack_fill < STACK_DEPTH) begin
            stack_fill++;
            top_nonzero = (value != 0);
         end
      end else if (cmd <= CMD_DIV && stack_fill >= 2) begin
         stack_fill--;
         top_nonzero = 1'b0;
      end
   endtask

   // The first edge lets the checker record the transaction accepted just now.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Random legal stream: no command here can trip an error.
   task automatic run_phase(input int count, input int push_bias);
      logic [2:0] op;
      bit         want_push;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 4) begin
            send_item(CMD_SPARE_FIRST + 3'($urandom_range(0, 2)), $urandom);
         end else begin
            want_push = (stack_fill < 2) ||
                        (stack_fill < STACK_DEPTH && $urandom_range(0, 99) < push_bias);
            if (want_push) begin
               send_item(CMD_PUSH, pick_value());
            end else begin
               op = pick_operation();
               if (op == CMD_DIV && !top_nonzero) begin
                  if (stack_fill < STACK_DEPTH) send_item(CMD_PUSH, pick_nonzero());
                  else op = CMD_SUB;
               end
               send_item(op, $urandom);
            end
         end
      end
   endtask

   task automatic provoke_halt();
      halt_cause_type cause;
      cause = halt_cause_type'($urandom_range(0, 2));
      case (cause)
         HALT_BY_FULL: begin
            while (stack_fill < STACK_DEPTH) send_item(CMD_PUSH, pick_value());
            send_item(CMD_PUSH, pick_value());
         end
         HALT_BY_FEW: begin
            while (stack_fill >= 2) send_item(CMD_ADD + 3'($urandom_range(0, 2)), $urandom);
            send_item(pick_operation(), $urandom);
         end
         default: begin
            if (stack_fill == STACK_DEPTH) send_item(CMD_ADD, $urandom);
            if (stack_fill == 0) send_item(CMD_PUSH, pick_value());
            send_item(CMD_PUSH, '0);
            send_item(CMD_DIV, $urandom);
         end
      endcase
      // Everything after the error must come back halted, spare codes included.
      repeat (12) send_item(3'($urandom), $urandom);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Spare codes on an empty stack, then saturation, rounding and truncation.
      send_item(CMD_SPARE_FIRST, VAL_MAX);
      send_item('1, VAL_MIN);
      send_item(CMD_PUSH, VAL_MAX);
      send_item(CMD_PUSH, VAL_MAX);
      send_item(CMD_ADD, '0);
      send_item(CMD_PUSH, VAL_MIN);
      send_item(CMD_SUB, '0);
      send_item(CMD_PUSH, VAL_MIN);
      send_item(CMD_ADD, '0);
      send_item(CMD_PUSH, VAL_MIN);
      send_item(CMD_ADD, '0);
      send_item(CMD_PUSH, VAL_MIN);
      send_item(CMD_MUL, '0);
      send_item(CMD_PUSH, -VAL_ULP);
      send_item(CMD_DIV, '0);
      send_item(CMD_PUSH, -VAL_ULP);
      send_item(CMD_DIV, '0);
      send_item(CMD_PUSH, VAL_HALF);
      send_item(CMD_PUSH, VAL_ULP);
      send_item(CMD_MUL, '0);
      send_item(CMD_PUSH, -VAL_ULP);
      send_item(CMD_MUL, '0);
      send_item(CMD_PUSH, -3 * VAL_ULP);
      send_item(CMD_PUSH, VAL_TWO);
      send_item(CMD_DIV, '0);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         tx_idle_on = (phase % 3 != 2);
         rx_idle_on = (phase % 3 != 1);
         // The receiver stops for a long stretch while requests keep coming.
         if (phase == 3) rx_hold_cycles = LONG_HOLD;
         if (phase == 5) wait_drained();
         run_phase(PHASE_ITEMS, $urandom_range(35, 65));
      end

      wait_drained();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      provoke_halt();
      wait_drained();
      repeat (END_WAIT) @(posedge clock);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
